FILE: hw/rtl/bcmh_pkg.sv
// Shared types, constants and helpers for the column BCM / homeostatic table.
// Used by bcmh_mem, bcmh_mul and column_bcm_homeostatic_update.
package bcmh_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);

    localparam logic [16:0] ONE_Q     = 17'd65536;
    localparam logic [19:0] SCALE_MIN = 20'd6554;
    localparam logic [19:0] SCALE_MAX = 20'd655360;
    localparam logic [40:0] CAP40     = 41'h100_0000_0000;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_BCM    = 3'd2,
        CMD_HOMEO  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_MODE      = 3'd0,
        CFG_INIT_THR  = 3'd1,
        CFG_BCM_ITAU  = 3'd2,
        CFG_CRIT_BCM  = 3'd3,
        CFG_HOM_ITAU  = 3'd4,
        CFG_CRIT_HOM  = 3'd5,
        CFG_TARGET    = 3'd6,
        CFG_TARGET_IN = 3'd7
    } t_cfg_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_LOAD, S_SH_RD, S_SH_WR, S_WB, S_DONE,
        S_B_SQ, S_B_AL, S_B_KA, S_B_AS, S_B_TG, S_B_KT, S_B_AT,
        S_H_AL, S_H_SP, S_H_REL, S_H_ADJ, S_H_SC
    } t_state;

    typedef struct packed {
        logic [31:0] thr;
        logic [31:0] avg;
        logic [19:0] scale;
        logic [31:0] rate;
        logic [31:0] cnt;
    } t_rec;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_rec             data;
    } t_mem_wr;

    // Q16.16 product saturated at 2^40
    function automatic logic [40:0] f_cap(input logic [73:0] full, input logic ovf);
        if (ovf || full[73:16] > {17'd0, CAP40}) begin
            return CAP40;
        end
        return full[56:16];
    endfunction

    function automatic logic [31:0] f_sat32(input logic [63:0] full);
        if (full[63:48] != 16'd0) begin
            return 32'hFFFF_FFFF;
        end
        return full[47:16];
    endfunction

endpackage

FILE: hw/rtl/bcmh_mem.sv
// Column record memory: one write port, one read port, registered read data.
// Depends on bcmh_pkg.
module bcmh_mem
    import bcmh_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    output t_rec             o_rd_data
);

    t_rec r_mem [MAX_COLUMNS];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/bcmh_mul.sv
// Multi-cycle 41x41 multiplier built on one 32x32 multiplier.
// Gives the full product when at most one operand exceeds 32 bits, else flags overflow.
// Depends on bcmh_pkg.
module bcmh_mul
    import bcmh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [40:0] i_a,
    input  logic [40:0] i_b,
    output logic        o_done,
    output logic [73:0] o_full,
    output logic        o_ovf
);

    logic [40:0] r_a, r_b;
    logic [63:0] r_lo, r_cross;
    logic [73:0] r_full;
    logic        r_ovf;
    logic        r_p1, r_p2, r_p3, r_p4;
    logic        a_hi;
    logic [31:0] m_x, m_y;
    logic [63:0] m_p;

    assign a_hi = (r_a[40:32] != 9'd0);
    assign m_x  = r_p1 ? r_a[31:0] : (a_hi ? {23'd0, r_a[40:32]} : r_a[31:0]);
    assign m_y  = r_p1 ? r_b[31:0] : (a_hi ? r_b[31:0] : {23'd0, r_b[40:32]});
    assign m_p  = m_x * m_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
            r_p3 <= 1'b0;
            r_p4 <= 1'b0;
        end else begin
            r_p1 <= i_start;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            r_p4 <= r_p3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_p1) begin
            r_lo <= m_p;
        end
        if (r_p2) begin
            r_cross <= m_p;
            r_ovf   <= a_hi && (r_b[40:32] != 9'd0);
        end
        if (r_p3) begin
            r_full <= {10'd0, r_lo} + {r_cross[41:0], 32'd0};
        end
    end

    assign o_done = r_p4;
    assign o_full = r_full;
    assign o_ovf  = r_ovf;

endmodule

FILE: hw/rtl/column_bcm_homeostatic_update.sv
// Column BCM / homeostatic plasticity table: top level, command sequencer.
// BCM and homeostatic updates run their steps in turn on the shared multiplier.
// Remove shifts every later column down by one slot. One request at a time; the next
// is taken as soon as the sequencer is idle. Synchronous reset clears the column count,
// totals, state and config registers; payload registers and memory are not cleared.
module column_bcm_homeostatic_update
    import bcmh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_column_index,
    input  logic [31:0] i_activity_value,
    input  logic [31:0] i_time_step,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_column_out,
    output logic [31:0] o_threshold_out,
    output logic [31:0] o_average_out,
    output logic [19:0] o_scale_out,
    output logic [31:0] o_rate_out,
    output logic [31:0] o_column_updates,
    output logic [6:0]  o_columns_in_use,
    output logic [31:0] o_bcm_update_total,
    output logic [31:0] o_homeo_update_total
);

    // configuration
    logic [2:0]  r_mode;
    logic [31:0] r_init_thr, r_bcm_itau, r_hom_itau, r_crit_hom, r_target, r_target_inv;
    logic [16:0] r_crit_bcm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 3'd6;
            r_init_thr   <= 32'd0;
            r_bcm_itau   <= 32'd0;
            r_crit_bcm   <= ONE_Q;
            r_hom_itau   <= 32'd0;
            r_crit_hom   <= {15'd0, ONE_Q};
            r_target     <= 32'd0;
            r_target_inv <= 32'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_MODE:      r_mode       <= i_cfg_data[2:0];
                CFG_INIT_THR:  r_init_thr   <= i_cfg_data;
                CFG_BCM_ITAU:  r_bcm_itau   <= i_cfg_data;
                CFG_CRIT_BCM:  r_crit_bcm   <= i_cfg_data[16:0];
                CFG_HOM_ITAU:  r_hom_itau   <= i_cfg_data;
                CFG_CRIT_HOM:  r_crit_hom   <= i_cfg_data;
                CFG_TARGET:    r_target     <= i_cfg_data;
                CFG_TARGET_IN: r_target_inv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    t_state            r_state, n_state;
    logic              r_go, n_go;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [31:0]       r_bcm_total, n_bcm_total, r_hom_total, n_hom_total;
    logic              r_o_valid, n_o_valid;

    // payload state
    t_cmd              r_cmd, n_cmd;
    logic [COL_W-1:0]  r_idx, n_idx, r_col, n_col, r_ptr, n_ptr;
    logic [31:0]       r_act, n_act, r_dt, n_dt;
    t_status           r_status, n_status;
    logic              r_show, n_show;
    t_rec              r_rec, n_rec;
    logic [31:0]       r_sq, n_sq;
    logic [16:0]       r_alpha, n_alpha;
    logic [48:0]       r_acc, n_acc;
    logic [40:0]       r_ha, n_ha, r_rel, n_rel, r_fac, n_fac;
    t_status           r_out_status, n_out_status;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    t_rec              r_out_rec, n_out_rec;

    // datapath helpers
    logic              accept, crit, hneg, cap_cmp;
    logic [16:0]       keep;
    logic [31:0]       herr;
    logic [49:0]       acc_sum;
    logic [40:0]       cap_res;
    logic [44:0]       scl;
    logic [40:0]       mul_a, mul_b;
    logic              mul_done, mul_ovf, is_mul;
    logic [73:0]       mul_full;
    t_mem_wr           mem_wr;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    t_rec              rd_data;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign crit    = r_mode[0];
    assign keep    = ONE_Q - r_alpha;
    assign hneg    = r_act > r_target;
    assign herr    = hneg ? r_act - r_target : r_target - r_act;
    assign acc_sum = {1'b0, r_acc} + {1'b0, mul_full[48:0]};
    assign cap_res = f_cap(mul_full, mul_ovf);
    assign cap_cmp = cap_res >= {24'd0, ONE_Q};
    assign scl     = mul_full[60:16];
    assign is_mul  = (r_state >= S_B_SQ);

    always_comb begin
        mul_a = 41'd0;
        mul_b = 41'd0;
        case (r_state)
            S_B_SQ:  begin mul_a = {9'd0, r_act};       mul_b = {9'd0, r_act}; end
            S_B_AL:  begin mul_a = {9'd0, r_dt};        mul_b = {9'd0, r_bcm_itau}; end
            S_B_KA:  begin mul_a = {24'd0, keep};       mul_b = {9'd0, r_rec.avg}; end
            S_B_AS:  begin mul_a = {24'd0, r_alpha};    mul_b = {9'd0, r_sq}; end
            S_B_TG:  begin mul_a = {9'd0, r_rec.avg};   mul_b = {24'd0, r_crit_bcm}; end
            S_B_KT:  begin mul_a = {24'd0, keep};       mul_b = {9'd0, r_rec.thr}; end
            S_B_AT:  begin mul_a = {24'd0, r_alpha};    mul_b = {9'd0, r_sq}; end
            S_H_AL:  begin mul_a = {9'd0, r_dt};        mul_b = {9'd0, r_hom_itau}; end
            S_H_SP:  begin mul_a = r_ha;                mul_b = {9'd0, r_crit_hom}; end
            S_H_REL: begin mul_a = {9'd0, herr};        mul_b = {9'd0, r_target_inv}; end
            S_H_ADJ: begin mul_a = r_ha;                mul_b = r_rel; end
            S_H_SC:  begin mul_a = {21'd0, r_rec.scale}; mul_b = r_fac; end
            default: ;
        endcase
    end

    bcmh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_full  (mul_full),
        .o_ovf   (mul_ovf)
    );

    always_comb begin
        mem_wr.en   = 1'b0;
        mem_wr.addr = r_col;
        mem_wr.data = r_rec;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        case (r_state)
            S_READ:  rd_en = 1'b1;
            S_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_ptr + 1'b1;
            end
            S_SH_WR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_ptr;
                mem_wr.data = rd_data;
            end
            S_WB:    mem_wr.en = 1'b1;
            default: ;
        endcase
    end

    bcmh_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_go         = 1'b0;
        n_count      = r_count;
        n_bcm_total  = r_bcm_total;
        n_hom_total  = r_hom_total;
        n_o_valid    = r_o_valid && i_stall;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_col        = r_col;
        n_ptr        = r_ptr;
        n_act        = r_act;
        n_dt         = r_dt;
        n_status     = r_status;
        n_show       = r_show;
        n_rec        = r_rec;
        n_sq         = r_sq;
        n_alpha      = r_alpha;
        n_acc        = r_acc;
        n_ha         = r_ha;
        n_rel        = r_rel;
        n_fac        = r_fac;
        n_out_status = r_out_status;
        n_out_col    = r_out_col;
        n_out_rec    = r_out_rec;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx    = i_column_index;
                    n_col    = i_column_index;
                    n_ptr    = i_column_index;
                    n_act    = i_activity_value;
                    n_dt     = i_time_step;
                    n_status = ST_OK;
                    n_show   = 1'b0;
                    n_state  = S_DONE;
                    case (t_cmd'(i_command))
                        CMD_ADD: begin
                            n_cmd = CMD_ADD;
                            if (r_count >= CNT_W'(MAX_COLUMNS)) begin
                                n_status = ST_FULL;
                                n_col    = '0;
                            end else begin
                                n_col       = r_count[COL_W-1:0];
                                n_rec.thr   = r_init_thr;
                                n_rec.avg   = 32'd0;
                                n_rec.scale = {3'd0, ONE_Q};
                                n_rec.rate  = 32'd0;
                                n_rec.cnt   = 32'd0;
                                n_show      = 1'b1;
                                n_state     = S_WB;
                            end
                        end
                        CMD_REMOVE: begin
                            n_cmd = CMD_REMOVE;
                            if ({1'b0, i_column_index} >= r_count) begin
                                n_status = ST_UNKNOWN;
                            end else if ({1'b0, i_column_index} + 1'b1 < r_count) begin
                                n_state = S_SH_RD;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_BCM: begin
                            n_cmd = CMD_BCM;
                            if (!r_mode[1]) begin
                                n_status = ST_DISABLED;
                            end else if ({1'b0, i_column_index} >= r_count) begin
                                n_status = ST_UNKNOWN;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        CMD_HOMEO: begin
                            n_cmd = CMD_HOMEO;
                            if (!r_mode[2]) begin
                                n_status = ST_DISABLED;
                            end else if ({1'b0, i_column_index} >= r_count) begin
                                n_status = ST_UNKNOWN;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_cmd = CMD_READ;
                            if ({1'b0, i_column_index} >= r_count) begin
                                n_status = ST_UNKNOWN;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                n_rec  = rd_data;
                n_show = 1'b1;
                case (r_cmd)
                    CMD_BCM: begin
                        n_rec.cnt   = rd_data.cnt + 1'b1;
                        n_bcm_total = r_bcm_total + 1'b1;
                        n_state     = S_B_SQ;
                        n_go        = 1'b1;
                    end
                    CMD_HOMEO: begin
                        n_rec.cnt   = rd_data.cnt + 1'b1;
                        n_rec.rate  = r_act;
                        n_hom_total = r_hom_total + 1'b1;
                        n_state     = S_H_AL;
                        n_go        = 1'b1;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: begin
                n_ptr = r_ptr + 1'b1;
                if ({1'b0, r_ptr} + 2'd2 < r_count) begin
                    n_state = S_SH_RD;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_WB: begin
                if (r_cmd == CMD_ADD) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid    = 1'b1;
                    n_out_status = r_status;
                    n_out_col    = r_col;
                    n_out_rec    = r_show ? r_rec : '0;
                    n_state      = S_IDLE;
                end
            end
            S_B_SQ: if (mul_done) begin
                n_sq    = f_sat32(mul_full[63:0]);
                n_state = S_B_AL;
                n_go    = 1'b1;
            end
            S_B_AL: if (mul_done) begin
                n_alpha = (mul_full[63:16] > {31'd0, ONE_Q}) ? ONE_Q : mul_full[32:16];
                n_state = S_B_KA;
                n_go    = 1'b1;
            end
            S_B_KA: if (mul_done) begin
                n_acc   = mul_full[48:0];
                n_state = S_B_AS;
                n_go    = 1'b1;
            end
            S_B_AS: if (mul_done) begin
                n_rec.avg = acc_sum[47:16];
                n_sq      = acc_sum[47:16];
                n_state   = crit ? S_B_TG : S_B_KT;
                n_go      = 1'b1;
            end
            S_B_TG: if (mul_done) begin
                n_sq    = f_sat32(mul_full[63:0]);
                n_state = S_B_KT;
                n_go    = 1'b1;
            end
            S_B_KT: if (mul_done) begin
                n_acc   = mul_full[48:0];
                n_state = S_B_AT;
                n_go    = 1'b1;
            end
            S_B_AT: if (mul_done) begin
                n_rec.thr = acc_sum[47:16];
                n_state   = S_WB;
            end
            S_H_AL: if (mul_done) begin
                n_ha    = cap_res;
                n_state = crit ? S_H_SP : S_H_REL;
                n_go    = 1'b1;
            end
            S_H_SP: if (mul_done) begin
                n_ha    = cap_res;
                n_state = S_H_REL;
                n_go    = 1'b1;
            end
            S_H_REL: if (mul_done) begin
                n_rel   = cap_res;
                n_state = S_H_ADJ;
                n_go    = 1'b1;
            end
            S_H_ADJ: if (mul_done) begin
                if (hneg && cap_cmp) begin
                    n_rec.scale = SCALE_MIN;
                    n_state     = S_WB;
                end else begin
                    n_fac   = hneg ? {24'd0, ONE_Q} - cap_res : {24'd0, ONE_Q} + cap_res;
                    n_state = S_H_SC;
                    n_go    = 1'b1;
                end
            end
            S_H_SC: if (mul_done) begin
                if (scl < {25'd0, SCALE_MIN}) begin
                    n_rec.scale = SCALE_MIN;
                end else if (scl > {25'd0, SCALE_MAX}) begin
                    n_rec.scale = SCALE_MAX;
                end else begin
                    n_rec.scale = scl[19:0];
                end
                n_state = S_WB;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_count     <= '0;
            r_bcm_total <= 32'd0;
            r_hom_total <= 32'd0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_count     <= n_count;
            r_bcm_total <= n_bcm_total;
            r_hom_total <= n_hom_total;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_col        <= n_col;
        r_ptr        <= n_ptr;
        r_act        <= n_act;
        r_dt         <= n_dt;
        r_status     <= n_status;
        r_show       <= n_show;
        r_rec        <= n_rec;
        r_sq         <= n_sq;
        r_alpha      <= n_alpha;
        r_acc        <= n_acc;
        r_ha         <= n_ha;
        r_rel        <= n_rel;
        r_fac        <= n_fac;
        r_out_status <= n_out_status;
        r_out_col    <= n_out_col;
        r_out_rec    <= n_out_rec;
    end

    // output totals are captured with the response
    logic [CNT_W-1:0] r_out_count;
    logic [31:0]      r_out_bcm, r_out_hom;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_o_valid || !i_stall)) begin
            r_out_count <= r_count;
            r_out_bcm   <= r_bcm_total;
            r_out_hom   <= r_hom_total;
        end
    end

    assign o_valid              = r_o_valid;
    assign o_status             = r_out_status;
    assign o_column_out         = r_out_col;
    assign o_threshold_out      = r_out_rec.thr;
    assign o_average_out        = r_out_rec.avg;
    assign o_scale_out          = r_out_rec.scale;
    assign o_rate_out           = r_out_rec.rate;
    assign o_column_updates     = r_out_rec.cnt;
    assign o_columns_in_use     = r_out_count;
    assign o_bcm_update_total   = r_out_bcm;
    assign o_homeo_update_total = r_out_hom;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_COLUMNS))
        else $error("column count above table size");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer idle");

    a_mul_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> is_mul)
        else $error("multiplier result outside an arithmetic step");

    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.en |-> ({1'b0, mem_wr.addr} <= r_count))
        else $error("memory write beyond table end");

    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_scale_out <= SCALE_MAX))
        else $error("scale out of range");

endmodule
